// File: rtl/spr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and constants for the shortest path relaxation block.
// ----------------------------------------------------------------------------
package spr_pkg;

   localparam int NODE_BITS         = 5;
   localparam int NODE_COUNT_BITS   = 6;
   localparam int WEIGHT_BITS       = 16;
   localparam int DIST_BITS         = 24;
   localparam int MAX_NODES         = 32;
   localparam int MAX_EDGES_DEFAULT = 256;
   localparam int CSR_INDEX_BITS    = 1;
   localparam int CSR_DATA_BITS     = 6;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_NODE = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NODE_COUNT  = 1'd1;

   localparam logic [NODE_BITS-1:0]       SOURCE_RESET = '0;
   localparam logic [NODE_COUNT_BITS-1:0] COUNT_RESET  = NODE_COUNT_BITS'(MAX_NODES);

   localparam logic [DIST_BITS-1:0] DIST_MAX = {1'b0, {(DIST_BITS-1){1'b1}}};
   localparam logic [DIST_BITS-1:0] DIST_MIN = {1'b1, {(DIST_BITS-1){1'b0}}};

   typedef struct packed {
      logic [NODE_BITS-1:0]          from_node;
      logic [NODE_BITS-1:0]          to_node;
      logic signed [WEIGHT_BITS-1:0] edge_weight;
      logic                          last_edge;
   } req_payload_type;

   typedef struct packed {
      logic [NODE_BITS-1:0]        node_index;
      logic signed [DIST_BITS-1:0] distance;
      logic                        reachable;
      logic                        negative_cycle;
      logic                        last_node;
   } rsp_payload_type;

   typedef struct packed {
      logic [NODE_BITS-1:0]          from_node;
      logic [NODE_BITS-1:0]          to_node;
      logic signed [WEIGHT_BITS-1:0] edge_weight;
   } edge_type;

   typedef struct packed {
      logic [DIST_BITS-1:0] candidate;
      logic                 improves;
   } relax_result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_EDGE_RD,
      ST_DIST_RD,
      ST_RELAX,
      ST_PASS_END,
      ST_OUT_RD,
      ST_OUT_WR
   } state_type;

endpackage

// File: rtl/shortest_path_relaxation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_path_relaxation
// Bellman-Ford single-source shortest paths over a loaded edge list.
// ----------------------------------------------------------------------------
// Usage: edges arrive on the req_ channel, one transaction per edge, one per
// cycle while idle; an edge with last_edge set starts a run. Edges beyond
// MAX_EDGES are dropped. csr_ writes set source_node (index 0) and
// node_count (index 1); they are always taken but belong in idle time.
// A run takes a set-up step, then passes over the stored edges, each closed
// by a pass-end step; at most node_count passes, stopping after a quiet pass.
// Each edge goes through edge memory read, distance memory read and a
// write-back, so one edge is fully retired before the next is read.
// Results follow on rsp_, one transaction per node 0 .. node_count-1, each
// from a distance memory read then the output register.
// req_ready is low from the last edge until the last result is loaded into
// the output register. A stalled receiver holds the output register and the
// read-out waits; the next graph may be loaded while the last result waits.
// Reset clears the edge count and reach marks and restores the registers;
// no clearing pass is needed, the block is ready in the cycle after reset.
// ----------------------------------------------------------------------------
module shortest_path_relaxation
   import spr_pkg::*;
#(
   parameter int MAX_EDGES = MAX_EDGES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_payload_type           req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_payload_type           rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

   logic                 edge_we;
   logic [EAW-1:0]       edge_waddr;
   edge_type             edge_wdata;
   logic [EAW-1:0]       edge_raddr;
   edge_type             edge_rdata;
   logic                 dist_we;
   logic [NODE_BITS-1:0] dist_waddr;
   logic [DIST_BITS-1:0] dist_wdata;
   logic [NODE_BITS-1:0] dist_raddr_a;
   logic [NODE_BITS-1:0] dist_raddr_b;
   logic [DIST_BITS-1:0] dist_rdata_a;
   logic [DIST_BITS-1:0] dist_rdata_b;
   relax_result_type     relax_result;

   spr_edge_mem #(
      .MAX_EDGES (MAX_EDGES)
   ) u_edge_mem (
      .clock (clock),
      .we    (edge_we),
      .waddr (edge_waddr),
      .wdata (edge_wdata),
      .raddr (edge_raddr),
      .rdata (edge_rdata)
   );

   spr_dist_mem u_dist_mem (
      .clock   (clock),
      .we      (dist_we),
      .waddr   (dist_waddr),
      .wdata   (dist_wdata),
      .raddr_a (dist_raddr_a),
      .raddr_b (dist_raddr_b),
      .rdata_a (dist_rdata_a),
      .rdata_b (dist_rdata_b)
   );

   spr_relax_unit u_relax (
      .dist_from (dist_rdata_a),
      .dist_to   (dist_rdata_b),
      .weight    (edge_rdata.edge_weight),
      .result    (relax_result)
   );

   spr_ctrl #(
      .MAX_EDGES (MAX_EDGES)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .edge_we      (edge_we),
      .edge_waddr   (edge_waddr),
      .edge_wdata   (edge_wdata),
      .edge_raddr   (edge_raddr),
      .edge_rdata   (edge_rdata),
      .dist_we      (dist_we),
      .dist_waddr   (dist_waddr),
      .dist_wdata   (dist_wdata),
      .dist_raddr_a (dist_raddr_a),
      .dist_raddr_b (dist_raddr_b),
      .dist_rdata_a (dist_rdata_a),
      .relax_result (relax_result)
   );

endmodule

// File: rtl/spr_edge_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_edge_mem
// Edge list storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module spr_edge_mem
   import spr_pkg::*;
#(
   parameter int MAX_EDGES = MAX_EDGES_DEFAULT,
   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
   input  logic           clock,
   input  logic           we,
   input  logic [EAW-1:0] waddr,
   input  edge_type       wdata,
   input  logic [EAW-1:0] raddr,
   output edge_type       rdata
);

   edge_type mem [MAX_EDGES];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// File: rtl/spr_dist_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_dist_mem
// Distance storage: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module spr_dist_mem
   import spr_pkg::*;
(
   input  logic                 clock,
   input  logic                 we,
   input  logic [NODE_BITS-1:0] waddr,
   input  logic [DIST_BITS-1:0] wdata,
   input  logic [NODE_BITS-1:0] raddr_a,
   input  logic [NODE_BITS-1:0] raddr_b,
   output logic [DIST_BITS-1:0] rdata_a,
   output logic [DIST_BITS-1:0] rdata_b
);

   logic [DIST_BITS-1:0] mem [MAX_NODES];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end

endmodule

// File: rtl/spr_relax_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_relax_unit
// Saturating candidate distance and compare against the current distance.
// ----------------------------------------------------------------------------
module spr_relax_unit
   import spr_pkg::*;
(
   input  logic [DIST_BITS-1:0]          dist_from,
   input  logic [DIST_BITS-1:0]          dist_to,
   input  logic signed [WEIGHT_BITS-1:0] weight,
   output relax_result_type              result
);

   logic [DIST_BITS:0]   sum;
   logic [DIST_BITS-1:0] candidate;

   assign sum = {dist_from[DIST_BITS-1], dist_from}
              + {{(DIST_BITS+1-WEIGHT_BITS){weight[WEIGHT_BITS-1]}}, weight};

   // overflow when the two top bits disagree
   always_comb begin
      if (sum[DIST_BITS] != sum[DIST_BITS-1]) begin
         candidate = sum[DIST_BITS] ? DIST_MIN : DIST_MAX;
      end else begin
         candidate = sum[DIST_BITS-1:0];
      end
   end

   assign result.candidate = candidate;
   assign result.improves  = $signed(candidate) < $signed(dist_to);

endmodule

// File: rtl/spr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_ctrl
// Sequencer: edge loading, relaxation passes, result read-out, registers.
// ----------------------------------------------------------------------------
module spr_ctrl
   import spr_pkg::*;
#(
   parameter int MAX_EDGES = MAX_EDGES_DEFAULT,
   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
   localparam int ETW = $clog2(MAX_EDGES + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_payload_type           req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_payload_type           rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output logic                      edge_we,
   output logic [EAW-1:0]            edge_waddr,
   output edge_type                  edge_wdata,
   output logic [EAW-1:0]            edge_raddr,
   input  edge_type                  edge_rdata,
   output logic                      dist_we,
   output logic [NODE_BITS-1:0]      dist_waddr,
   output logic [DIST_BITS-1:0]      dist_wdata,
   output logic [NODE_BITS-1:0]      dist_raddr_a,
   output logic [NODE_BITS-1:0]      dist_raddr_b,
   input  logic [DIST_BITS-1:0]      dist_rdata_a,
   input  relax_result_type          relax_result
);

   state_type                  state_ff, state_in;
   logic [ETW-1:0]             total_ff, total_in;
   logic [ETW-1:0]             edge_ff, edge_in;
   logic [NODE_COUNT_BITS-1:0] pass_ff, pass_in;
   logic [NODE_BITS-1:0]       node_ff, node_in;
   logic [NODE_COUNT_BITS-1:0] n_ff, n_in;
   logic [NODE_BITS-1:0]       source_ff, source_in;
   logic [NODE_COUNT_BITS-1:0] count_ff, count_in;
   logic                       updated_ff, updated_in;
   logic [MAX_NODES-1:0]       reached_ff, reached_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_payload_type            rsp_payload_ff, rsp_payload_in;

   logic [NODE_COUNT_BITS-1:0] n_clamped;
   logic                       req_accept;
   logic                       edge_live;
   logic                       relax_take;
   logic                       more_passes;
   logic                       out_load;
   logic                       node_last;
   logic                       edges_done;

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_accept  = req_valid && req_ready;
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      if (count_ff == '0) begin
         n_clamped = NODE_COUNT_BITS'(1);
      end else if (count_ff > NODE_COUNT_BITS'(MAX_NODES)) begin
         n_clamped = NODE_COUNT_BITS'(MAX_NODES);
      end else begin
         n_clamped = count_ff;
      end
   end

   // edges touching unused nodes or leaving unreached nodes are skipped
   assign edge_live = ({1'b0, edge_rdata.from_node} < n_ff)
                   && ({1'b0, edge_rdata.to_node} < n_ff)
                   && reached_ff[edge_rdata.from_node];
   assign relax_take  = edge_live
                     && (!reached_ff[edge_rdata.to_node] || relax_result.improves);
   assign more_passes = updated_ff && (pass_ff + NODE_COUNT_BITS'(1) != n_ff);
   assign out_load    = (state_ff == ST_OUT_WR) && (!rsp_valid_ff || rsp_ready);
   assign node_last   = ({1'b0, node_ff} + NODE_COUNT_BITS'(1)) == n_ff;
   assign edges_done  = (edge_ff == total_ff);

   assign edge_waddr   = total_ff[EAW-1:0];
   assign edge_raddr   = edge_ff[EAW-1:0];
   assign edge_wdata   = '{from_node:   req_payload.from_node,
                           to_node:     req_payload.to_node,
                           edge_weight: req_payload.edge_weight};
   assign dist_raddr_a = (state_ff == ST_OUT_RD || state_ff == ST_OUT_WR)
                       ? node_ff : edge_rdata.from_node;
   assign dist_raddr_b = edge_rdata.to_node;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_payload.last_edge) begin
               state_in = ST_INIT;
            end
         end
         ST_INIT:     state_in = ST_EDGE_RD;
         ST_EDGE_RD:  state_in = edges_done ? ST_PASS_END : ST_DIST_RD;
         ST_DIST_RD:  state_in = ST_RELAX;
         ST_RELAX:    state_in = ST_EDGE_RD;
         ST_PASS_END: state_in = more_passes ? ST_EDGE_RD : ST_OUT_RD;
         ST_OUT_RD:   state_in = ST_OUT_WR;
         ST_OUT_WR: begin
            if (out_load) begin
               state_in = node_last ? ST_IDLE : ST_OUT_RD;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      total_in       = total_ff;
      edge_in        = edge_ff;
      pass_in        = pass_ff;
      node_in        = node_ff;
      n_in           = n_ff;
      updated_in     = updated_ff;
      reached_in     = reached_ff;
      rsp_payload_in = rsp_payload_ff;
      edge_we        = 1'b0;
      dist_we        = 1'b0;
      dist_waddr     = edge_rdata.to_node;
      dist_wdata     = relax_result.candidate;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (total_ff < ETW'(MAX_EDGES)) begin
                  edge_we  = 1'b1;
                  total_in = total_ff + ETW'(1);
               end
               n_in = n_clamped;
            end
         end
         ST_INIT: begin
            reached_in = '0;
            updated_in = 1'b0;
            pass_in    = '0;
            edge_in    = '0;
            if ({1'b0, source_ff} < n_ff) begin
               reached_in[source_ff] = 1'b1;
               dist_we    = 1'b1;
               dist_waddr = source_ff;
               dist_wdata = '0;
            end
         end
         ST_RELAX: begin
            edge_in = edge_ff + ETW'(1);
            if (relax_take) begin
               dist_we                         = 1'b1;
               reached_in[edge_rdata.to_node]  = 1'b1;
               updated_in                      = 1'b1;
            end
         end
         ST_PASS_END: begin
            if (more_passes) begin
               pass_in    = pass_ff + NODE_COUNT_BITS'(1);
               updated_in = 1'b0;
               edge_in    = '0;
            end else begin
               node_in = '0;
            end
         end
         ST_OUT_WR: begin
            if (out_load) begin
               rsp_payload_in.node_index     = node_ff;
               rsp_payload_in.distance       = reached_ff[node_ff] ? dist_rdata_a : DIST_MAX;
               rsp_payload_in.reachable      = reached_ff[node_ff];
               rsp_payload_in.negative_cycle = updated_ff;
               rsp_payload_in.last_node      = node_last;
               node_in = node_ff + NODE_BITS'(1);
               if (node_last) begin
                  total_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);

   always_comb begin
      source_in = source_ff;
      count_in  = count_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SOURCE_NODE: source_in = csr_wdata[NODE_BITS-1:0];
            CSR_NODE_COUNT:  count_in  = csr_wdata[NODE_COUNT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         edge_ff      <= '0;
         pass_ff      <= '0;
         node_ff      <= '0;
         n_ff         <= NODE_COUNT_BITS'(MAX_NODES);
         source_ff    <= SOURCE_RESET;
         count_ff     <= COUNT_RESET;
         updated_ff   <= 1'b0;
         reached_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         edge_ff      <= edge_in;
         pass_ff      <= pass_in;
         node_ff      <= node_in;
         n_ff         <= n_in;
         source_ff    <= source_in;
         count_ff     <= count_in;
         updated_ff   <= updated_in;
         reached_ff   <= reached_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   a_relax_from_reached: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RELAX && dist_we) |-> reached_ff[edge_rdata.from_node])
      else $error("distance written from an unreached node");

   a_source_marked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT && ({1'b0, source_ff} < n_ff)) |=> reached_ff[$past(source_ff)])
      else $error("source node not marked at run start");

   a_pass_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PASS_END) |-> (pass_ff < n_ff))
      else $error("pass count beyond node count");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= ETW'(MAX_EDGES))
      else $error("edge count beyond store depth");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (out_load && rsp_payload_in.last_node) |=> (state_ff == ST_IDLE && total_ff == '0))
      else $error("run did not end after its last result");

endmodule
